### hw/rtl/hsj_pkg.sv
// shared constants and types of the halton sub-pixel jitter block
`default_nettype none

package hsj_pkg;

  localparam int FRAME_W = 32;          // frame index width
  localparam int CFG_W   = 15;          // width of the width registers
  localparam int CIDX_W  = 2;           // register index width
  localparam int OUT_W   = 16;          // jitter output width
  localparam int PH_W    = 34;          // phase count width
  localparam int IDX_W   = FRAME_W + 1; // sequence index, up to 2^32
  localparam int DIG_N   = 21;          // base-3 digits, 3^21 > 2^32

  localparam logic [CIDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RENDER  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_DISPLAY = 2'd2;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -16'sh8000;

  typedef struct packed {
    logic            busy;
    logic [PH_W-1:0] phase;
  } ph_stat_t;

endpackage

`default_nettype wire

### hw/rtl/halton_subpixel_jitter_top.sv
// top level of the halton sub-pixel jitter generator
//
//   port group   direction  handshake          payload
//   cfg_         in         cfg_we             cfg_index, cfg_data
//   in_          in         in_valid/in_stall  in_frame_index
//   out_         out        out_valid/out_stall out_jitter_x, out_jitter_y
//
// one item at a time: frame mod phase, then base-3 conversion, then FRAC_BITS
// fraction bits; when off, the item goes straight to the result
// a register write starts the phase count unit: serial squares of the 15-bit widths,
// a load step and a 35-step division; in_stall stays high until the division ends
// a finished result waits in the output register while the next item is taken
// reset is synchronous and returns the register defaults
`default_nettype none

module halton_subpixel_jitter_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hsj_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [hsj_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hsj_pkg::FRAME_W-1:0]        in_frame_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [hsj_pkg::OUT_W-1:0]   out_jitter_x,
  output logic signed [hsj_pkg::OUT_W-1:0]   out_jitter_y
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_DIG  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic                              en_r;
  logic [hsj_pkg::CFG_W-1:0]         rend_r;
  logic [hsj_pkg::CFG_W-1:0]         disp_r;
  logic                              ph_go_r;
  logic [1:0]                        st_r;
  logic                              zero_r;
  logic                              out_valid_r;
  logic signed [hsj_pkg::OUT_W-1:0]  ojx_r;
  logic signed [hsj_pkg::OUT_W-1:0]  ojy_r;

  hsj_pkg::ph_stat_t                 ph;
  logic                              in_acc;
  logic                              zero_req;
  logic                              out_free;
  logic                              md_start;
  logic                              md_done;
  logic [hsj_pkg::IDX_W-1:0]         idx;
  logic                              dg_start;
  logic                              dg_done;
  logic [FRAC_BITS-1:0]              s2;
  logic [FRAC_BITS-1:0]              s3;
  logic signed [FRAC_BITS-1:0]       vx;
  logic signed [FRAC_BITS-1:0]       vy;
  logic signed [hsj_pkg::OUT_W-1:0]  jx;
  logic signed [hsj_pkg::OUT_W-1:0]  jy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      rend_r  <= '0;
      disp_r  <= hsj_pkg::CFG_W'(1);
      ph_go_r <= 1'b0;
    end else begin
      ph_go_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          hsj_pkg::REG_ENABLE:  en_r   <= cfg_data[0];
          hsj_pkg::REG_RENDER:  rend_r <= cfg_data;
          hsj_pkg::REG_DISPLAY: disp_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  hsj_phase u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ph_go_r),
    .disp  (disp_r),
    .rend  (rend_r),
    .stat  (ph)
  );

  assign in_stall = (st_r != S_IDLE) | ph.busy | ph_go_r;
  assign in_acc   = in_valid & ~in_stall;
  assign zero_req = ~en_r | (rend_r == '0);
  assign out_free = ~out_valid_r | ~out_stall;
  assign md_start = in_acc & ~zero_req;
  assign dg_start = (st_r == S_MOD) & md_done;

  hsj_modidx u_modidx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .frame (in_frame_index),
    .phase (ph.phase),
    .done  (md_done),
    .idx   (idx)
  );

  hsj_digits #(
    .FRAC_BITS (FRAC_BITS)
  ) u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dg_start),
    .idx   (idx),
    .done  (dg_done),
    .s2    (s2),
    .s3    (s3)
  );

  // subtracting one half flips the top fraction bit
  assign vx = {~s2[FRAC_BITS-1], s2[FRAC_BITS-2:0]};
  assign vy = {~s3[FRAC_BITS-1], s3[FRAC_BITS-2:0]};

  if (FRAC_BITS > hsj_pkg::OUT_W) begin : g_sat
    localparam logic signed [FRAC_BITS-1:0] VMAX = FRAC_BITS'(hsj_pkg::OUT_MAX);
    localparam logic signed [FRAC_BITS-1:0] VMIN = FRAC_BITS'(hsj_pkg::OUT_MIN);
    always_comb begin
      if (vx > VMAX) begin
        jx = hsj_pkg::OUT_MAX;
      end else if (vx < VMIN) begin
        jx = hsj_pkg::OUT_MIN;
      end else begin
        jx = vx[hsj_pkg::OUT_W-1:0];
      end
      if (vy > VMAX) begin
        jy = hsj_pkg::OUT_MAX;
      end else if (vy < VMIN) begin
        jy = hsj_pkg::OUT_MIN;
      end else begin
        jy = vy[hsj_pkg::OUT_W-1:0];
      end
    end
  end else begin : g_ext
    assign jx = hsj_pkg::OUT_W'(vx);
    assign jy = hsj_pkg::OUT_W'(vy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            zero_r <= zero_req;
            st_r   <= zero_req ? S_DONE : S_MOD;
          end
        end
        S_MOD: begin
          if (md_done) begin
            st_r <= S_DIG;
          end
        end
        S_DIG: begin
          if (dg_done) begin
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
      if ((st_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == S_DONE) && out_free) begin
      ojx_r <= zero_r ? '0 : jx;
      ojy_r <= zero_r ? '0 : jy;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_jitter_x = ojx_r;
  assign out_jitter_y = ojy_r;

  a_phase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !ph.busy |-> (ph.phase != '0))
    else $error("phase count is zero");

  a_digits_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    dg_done |-> (st_r == S_DIG))
    else $error("digit unit finished outside its step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_DONE))
    else $error("result shown without a finished item");

endmodule

`default_nettype wire

### hw/rtl/hsj_phase.sv
// phase count unit: serial squares of both widths, then restoring division
`default_nettype none

module hsj_phase (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hsj_pkg::CFG_W-1:0]  disp,
  input  logic [hsj_pkg::CFG_W-1:0]  rend,
  output hsj_pkg::ph_stat_t          stat
);

  localparam int SQ_W  = 2 * hsj_pkg::CFG_W;
  localparam int N_W   = SQ_W + 5;
  localparam int M_W   = SQ_W + 1;
  localparam int CNT_W = $clog2(N_W);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_SQ   = 2'd1;
  localparam logic [1:0] P_LD   = 2'd2;
  localparam logic [1:0] P_DIV  = 2'd3;

  logic [1:0]                  st_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [hsj_pkg::PH_W-1:0]    phase_r;
  logic [hsj_pkg::CFG_W-1:0]   mqd_r;
  logic [hsj_pkg::CFG_W-1:0]   mqr_r;
  logic [SQ_W-1:0]             mcd_r;
  logic [SQ_W-1:0]             mcr_r;
  logic [SQ_W-1:0]             sqd_r;
  logic [SQ_W-1:0]             sqr_r;
  logic [N_W-1:0]              nq_r;
  logic [M_W-1:0]              rm_r;
  logic [M_W-1:0]              dv_r;

  logic [M_W:0]                sh;
  logic [M_W:0]                df;
  logic                        ge;
  logic [N_W-1:0]              nq_nxt;
  logic [M_W-1:0]              rm_nxt;
  logic [N_W-1:0]              numer;

  always_comb begin
    sh     = {rm_r, nq_r[N_W-1]};
    ge     = (sh >= {1'b0, dv_r});
    df     = sh - {1'b0, dv_r};
    nq_nxt = {nq_r[N_W-2:0], ge};
    rm_nxt = ge ? df[M_W-1:0] : sh[M_W-1:0];
    // 16*D*D + R*R
    numer  = N_W'({sqd_r, 4'b0000}) + N_W'(sqr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= P_IDLE;
      cnt_r   <= '0;
      phase_r <= hsj_pkg::PH_W'(1);
    end else if (start) begin
      st_r  <= P_SQ;
      cnt_r <= CNT_W'(hsj_pkg::CFG_W - 1);
    end else begin
      case (st_r)
        P_SQ: begin
          if (cnt_r == '0) begin
            st_r <= P_LD;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        P_LD: begin
          st_r  <= P_DIV;
          cnt_r <= CNT_W'(N_W - 1);
        end
        P_DIV: begin
          if (cnt_r == '0) begin
            st_r <= P_IDLE;
            // a zero quotient counts as one phase
            phase_r <= (nq_nxt == '0) ? hsj_pkg::PH_W'(1) : nq_nxt[hsj_pkg::PH_W-1:0];
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        default: st_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mqd_r <= disp;
      mqr_r <= rend;
      mcd_r <= SQ_W'(disp);
      mcr_r <= SQ_W'(rend);
      sqd_r <= '0;
      sqr_r <= '0;
    end else if (st_r == P_SQ) begin
      if (mqd_r[0]) begin
        sqd_r <= sqd_r + mcd_r;
      end
      if (mqr_r[0]) begin
        sqr_r <= sqr_r + mcr_r;
      end
      mqd_r <= mqd_r >> 1;
      mqr_r <= mqr_r >> 1;
      mcd_r <= mcd_r << 1;
      mcr_r <= mcr_r << 1;
    end else if (st_r == P_LD) begin
      nq_r <= numer;
      rm_r <= '0;
      dv_r <= {sqr_r, 1'b0};
    end else if (st_r == P_DIV) begin
      nq_r <= nq_nxt;
      rm_r <= rm_nxt;
    end
  end

  always_comb begin
    stat.busy  = (st_r != P_IDLE);
    stat.phase = phase_r;
  end

endmodule

`default_nettype wire

### hw/rtl/hsj_modidx.sv
// sequence index unit: frame mod phase by restoring division, plus one
`default_nettype none

module hsj_modidx (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hsj_pkg::FRAME_W-1:0] frame,
  input  logic [hsj_pkg::PH_W-1:0]    phase,
  output logic                        done,
  output logic [hsj_pkg::IDX_W-1:0]   idx
);

  localparam int CNT_W = $clog2(hsj_pkg::FRAME_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [hsj_pkg::FRAME_W-1:0] quo_r;
  logic [hsj_pkg::FRAME_W-1:0] rem_r;

  logic [hsj_pkg::FRAME_W:0]   sh;
  logic [hsj_pkg::PH_W-1:0]    df;
  logic                        ge;
  logic [hsj_pkg::FRAME_W-1:0] rem_nxt;

  // the partial remainder never exceeds the frame bits taken so far
  always_comb begin
    sh      = {rem_r, quo_r[hsj_pkg::FRAME_W-1]};
    ge      = (hsj_pkg::PH_W'(sh) >= phase);
    df      = hsj_pkg::PH_W'(sh) - phase;
    rem_nxt = ge ? df[hsj_pkg::FRAME_W-1:0] : sh[hsj_pkg::FRAME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(hsj_pkg::FRAME_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= frame;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign idx  = hsj_pkg::IDX_W'(rem_r) + hsj_pkg::IDX_W'(1);

endmodule

`default_nettype wire

### hw/rtl/hsj_digits.sv
// radical inverse unit: base-3 digit register and fraction bits, one bit per cycle
`default_nettype none

module hsj_digits #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hsj_pkg::IDX_W-1:0] idx,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      s2,
  output logic [FRAC_BITS-1:0]      s3
);

  localparam int CNT_W = $clog2(hsj_pkg::IDX_W);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CONV = 2'd1;
  localparam logic [1:0] D_FRAC = 2'd2;

  typedef logic [1:0] trit_t;
  typedef trit_t [hsj_pkg::DIG_N-1:0] trit_vec_t;
  typedef struct packed {
    logic      cy;
    trit_vec_t d;
  } tdbl_t;

  // doubles the integer and adds cin, carry ripples up from the least digit
  function automatic trit_vec_t dbl_up(input trit_vec_t d, input logic cin);
    trit_vec_t  r;
    logic       c;
    logic [2:0] t;
    c = cin;
    for (int k = 0; k < hsj_pkg::DIG_N; k++) begin
      t = {d[k], 1'b0} + {2'b00, c};
      if (t >= 3'd3) begin
        r[k] = 2'(t - 3'd3);
        c    = 1'b1;
      end else begin
        r[k] = t[1:0];
        c    = 1'b0;
      end
    end
    return r;
  endfunction

  // doubles the fraction 0.d0 d1 d2 ..., carry out is the next binary bit
  function automatic tdbl_t dbl_down(input trit_vec_t d);
    tdbl_t      r;
    logic       c;
    logic [2:0] t;
    c = 1'b0;
    for (int k = hsj_pkg::DIG_N - 1; k >= 0; k--) begin
      t = {d[k], 1'b0} + {2'b00, c};
      if (t >= 3'd3) begin
        r.d[k] = 2'(t - 3'd3);
        c      = 1'b1;
      end else begin
        r.d[k] = t[1:0];
        c      = 1'b0;
      end
    end
    r.cy = c;
    return r;
  endfunction

  logic [1:0]                st_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      done_r;
  logic [hsj_pkg::IDX_W-1:0] ib_r;
  trit_vec_t                 dig_r;
  logic [FRAC_BITS-1:0]      b2_r;
  logic [FRAC_BITS-1:0]      s2_r;
  logic [FRAC_BITS-1:0]      s3_r;

  trit_vec_t                 up_nxt;
  tdbl_t                     dn_nxt;

  always_comb begin
    up_nxt = dbl_up(dig_r, ib_r[hsj_pkg::IDX_W-1]);
    dn_nxt = dbl_down(dig_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        st_r  <= D_CONV;
        cnt_r <= CNT_W'(hsj_pkg::IDX_W - 1);
      end else begin
        case (st_r)
          D_CONV: begin
            if (cnt_r == '0) begin
              st_r  <= D_FRAC;
              cnt_r <= CNT_W'(FRAC_BITS - 1);
            end else begin
              cnt_r <= cnt_r - CNT_W'(1);
            end
          end
          D_FRAC: begin
            if (cnt_r == '0) begin
              st_r   <= D_IDLE;
              done_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r - CNT_W'(1);
            end
          end
          default: st_r <= D_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ib_r  <= idx;
      dig_r <= '0;
      b2_r  <= idx[FRAC_BITS-1:0];
    end else if (st_r == D_CONV) begin
      // index enters msb first into the base-3 register
      ib_r  <= ib_r << 1;
      dig_r <= up_nxt;
    end else if (st_r == D_FRAC) begin
      dig_r <= dn_nxt.d;
      s3_r  <= {s3_r[FRAC_BITS-2:0], dn_nxt.cy};
      // base 2: index bits come out reversed
      s2_r  <= {s2_r[FRAC_BITS-2:0], b2_r[0]};
      b2_r  <= b2_r >> 1;
    end
  end

  assign done = done_r;
  assign s2   = s2_r;
  assign s3   = s3_r;

endmodule

`default_nettype wire

### sim/halton_subpixel_jitter_top_test.sv
// testbench of the halton sub-pixel jitter block: directed table, random frames, self-check
module halton_subpixel_jitter_top_test;

  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int N_ROWS      = 20;

  typedef struct {
    logic signed [hsj_pkg::OUT_W-1:0] x;
    logic signed [hsj_pkg::OUT_W-1:0] y;
  } jitter_t;

  // one row of the directed table; set_cfg writes en/rw/dw first
  typedef struct packed {
    logic                             set_cfg;
    logic                             en;
    logic [hsj_pkg::CFG_W-1:0]        rw;
    logic [hsj_pkg::CFG_W-1:0]        dw;
    logic [hsj_pkg::FRAME_W-1:0]      frame;
    logic                             known;
    logic signed [hsj_pkg::OUT_W-1:0] x;
    logic signed [hsj_pkg::OUT_W-1:0] y;
  } frame_row_t;

  localparam frame_row_t FRAME_ROWS [N_ROWS] = '{
    // reset defaults: disabled
    '{1'b0, 1'b0, 15'd0,     15'd1,     32'h12345678, 1'b1, 16'sd0,      16'sd0},
    // zero render width, then disabled
    '{1'b1, 1'b1, 15'd0,     15'd100,   32'h00000005, 1'b1, 16'sd0,      16'sd0},
    '{1'b1, 1'b0, 15'd16384, 15'd16384, 32'h00000007, 1'b1, 16'sd0,      16'sd0},
    // equal widths: eight phases
    '{1'b1, 1'b1, 15'd16384, 15'd16384, 32'h00000000, 1'b1, 16'sd0,      -16'sd10923},
    '{1'b0, 1'b1, 15'd16384, 15'd16384, 32'h00000001, 1'b1, -16'sd16384, 16'sd10922},
    '{1'b0, 1'b1, 15'd16384, 15'd16384, 32'h00000003, 1'b1, -16'sd24576, -16'sd3641},
    '{1'b0, 1'b1, 15'd16384, 15'd16384, 32'h00000007, 1'b1, -16'sd28672, 16'sd25486},
    '{1'b0, 1'b1, 15'd16384, 15'd16384, 32'h00000008, 1'b1, 16'sd0,      -16'sd10923},
    '{1'b0, 1'b1, 15'd16384, 15'd16384, 32'hFFFFFFFF, 1'b1, -16'sd28672, 16'sd25486},
    // zero display width and a phase count that rounds to zero: always index 1
    '{1'b1, 1'b1, 15'd100,   15'd0,     32'hFFFFFFFF, 1'b1, 16'sd0,      -16'sd10923},
    '{1'b1, 1'b1, 15'd16384, 15'd1,     32'hAAAAAAAA, 1'b1, 16'sd0,      -16'sd10923},
    // largest phase count, then other width pairs
    '{1'b1, 1'b1, 15'd1,     15'd16384, 32'hFFFFFFFF, 1'b0, 16'sd0,      16'sd0},
    '{1'b0, 1'b1, 15'd1,     15'd16384, 32'h00000000, 1'b1, 16'sd0,      -16'sd10923},
    '{1'b0, 1'b1, 15'd1,     15'd16384, 32'h55555555, 1'b0, 16'sd0,      16'sd0},
    '{1'b0, 1'b1, 15'd1,     15'd16384, 32'hAAAAAAAA, 1'b0, 16'sd0,      16'sd0},
    '{1'b0, 1'b1, 15'd1,     15'd16384, 32'h7FFFFFFF, 1'b0, 16'sd0,      16'sd0},
    '{1'b1, 1'b1, 15'd1,     15'd1,     32'h00000002, 1'b1, 16'sd16384,  -16'sd25487},
    '{1'b1, 1'b1, 15'd3,     15'd2,     32'hFFFFFFFF, 1'b1, -16'sd24576, -16'sd3641},
    '{1'b1, 1'b1, 15'd16383, 15'd16384, 32'h80000000, 1'b0, 16'sd0,      16'sd0},
    '{1'b0, 1'b1, 15'd16383, 15'd16384, 32'h00000001, 1'b0, 16'sd0,      16'sd0}
  };

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [hsj_pkg::CIDX_W-1:0]       cfg_index = hsj_pkg::REG_ENABLE;
  logic [hsj_pkg::CFG_W-1:0]        cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [hsj_pkg::FRAME_W-1:0]      in_frame_index = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [hsj_pkg::OUT_W-1:0] out_jitter_x;
  logic signed [hsj_pkg::OUT_W-1:0] out_jitter_y;

  // register copies seen by the predictor
  logic                      cur_enable;
  logic [hsj_pkg::CFG_W-1:0] cur_render;
  logic [hsj_pkg::CFG_W-1:0] cur_display;

  jitter_t     pending_jitter [$];
  int unsigned n_bad = 0;
  int unsigned n_cycles = 0;

  halton_subpixel_jitter_top #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_index (in_frame_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_jitter_x   (out_jitter_x),
    .out_jitter_y   (out_jitter_y)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // floor(radical inverse of seq in base * 2^FRAC_BITS), exact
  function automatic longint unsigned radical_scaled(input longint unsigned seq,
                                                     input longint unsigned base);
    longint unsigned num;
    longint unsigned den;
    num = 0;
    den = 1;
    while (seq != 0) begin
      num = num * base + seq % base;
      den = den * base;
      seq = seq / base;
    end
    return (num << FRAC_BITS) / den;
  endfunction

  function automatic logic signed [hsj_pkg::OUT_W-1:0] centered(
      input longint unsigned scaled);
    longint v;
    v = longint'(scaled) - (longint'(1) << (FRAC_BITS - 1));
    if (v > hsj_pkg::OUT_MAX) v = hsj_pkg::OUT_MAX;
    if (v < hsj_pkg::OUT_MIN) v = hsj_pkg::OUT_MIN;
    return v[hsj_pkg::OUT_W-1:0];
  endfunction

  function automatic jitter_t predict_jitter(input logic [hsj_pkg::FRAME_W-1:0] frame);
    jitter_t         j;
    longint unsigned r;
    longint unsigned d;
    longint unsigned ph;
    longint unsigned seq;
    j.x = '0;
    j.y = '0;
    r = cur_render;
    d = cur_display;
    if (cur_enable && r != 0) begin
      ph = (64'd16 * d * d + r * r) / (64'd2 * r * r);
      if (ph == 0) ph = 1;
      seq = longint'(frame) % ph + 1;
      j.x = centered(radical_scaled(seq, 2));
      j.y = centered(radical_scaled(seq, 3));
    end
    return j;
  endfunction

  // mostly back to back, sometimes short, rarely long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  task automatic idle_gap(input bit no_idle);
    int n;
    n = no_idle ? 0 : gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [hsj_pkg::FRAME_W-1:0] frame, input jitter_t exp);
    in_valid       <= 1'b1;
    in_frame_index <= frame;
    do @(posedge clk); while (in_stall);
    pending_jitter.push_back(exp);
  endtask

  // block idle: every result back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_jitter.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic en, input logic [hsj_pkg::CFG_W-1:0] rw,
                           input logic [hsj_pkg::CFG_W-1:0] dw);
    cfg_we    <= 1'b1;
    cfg_index <= hsj_pkg::REG_ENABLE;
    cfg_data  <= hsj_pkg::CFG_W'(en);
    @(posedge clk);
    cfg_index <= hsj_pkg::REG_RENDER;
    cfg_data  <= rw;
    @(posedge clk);
    cfg_index <= hsj_pkg::REG_DISPLAY;
    cfg_data  <= dw;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_enable  = en;
    cur_render  = rw;
    cur_display = dw;
  endtask

  always @(posedge clk) begin
    n_cycles = n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    jitter_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_jitter.size() == 0) begin
        $error("unexpected item: jitter_x %0d jitter_y %0d", out_jitter_x, out_jitter_y);
        n_bad = n_bad + 1;
      end else begin
        e = pending_jitter.pop_front();
        if (out_jitter_x !== e.x) begin
          $error("jitter_x mismatch: expected %0d, got %0d", e.x, out_jitter_x);
          n_bad = n_bad + 1;
        end
        if (out_jitter_y !== e.y) begin
          $error("jitter_y mismatch: expected %0d, got %0d", e.y, out_jitter_y);
          n_bad = n_bad + 1;
        end
      end
    end
  end

  // result side: ready runs, sometimes long, broken by stalls
  initial begin
    int n;
    forever begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800) : $urandom_range(1, 30);
      out_stall <= 1'b0;
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    jitter_t                   exp;
    logic [hsj_pkg::CFG_W-1:0] rw;
    int                        dw;
    int                        n_items;
    bit                        no_idle;

    cur_enable  = 1'b0;
    cur_render  = '0;
    cur_display = hsj_pkg::CFG_W'(1);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (FRAME_ROWS[i].set_cfg) begin
        drain();
        apply_cfg(FRAME_ROWS[i].en, FRAME_ROWS[i].rw, FRAME_ROWS[i].dw);
      end
      idle_gap(1'b0);
      if (FRAME_ROWS[i].known) begin
        exp.x = FRAME_ROWS[i].x;
        exp.y = FRAME_ROWS[i].y;
      end else begin
        exp = predict_jitter(FRAME_ROWS[i].frame);
      end
      send_frame(FRAME_ROWS[i].frame, exp);
    end

    for (int s = 0; s < 14; s++) begin
      drain();
      rw = ($urandom_range(0, 7) == 0) ? hsj_pkg::CFG_W'($urandom_range(0, 16384))
                                       : hsj_pkg::CFG_W'($urandom_range(1, 16384));
      case ($urandom_range(0, 3))
        0: dw = $urandom_range(1, 16384);
        1: dw = int'(rw) * $urandom_range(1, 4) / $urandom_range(1, 4);
        2: dw = 16384;
        default: dw = $urandom_range(0, 16);
      endcase
      if (dw > 16384) dw = 16384;
      apply_cfg($urandom_range(0, 9) != 0, rw, hsj_pkg::CFG_W'(dw));
      no_idle = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(60, 110);
      for (int k = 0; k < n_items; k++) begin
        logic [hsj_pkg::FRAME_W-1:0] f;
        f = ($urandom_range(0, 3) == 0) ? hsj_pkg::FRAME_W'($urandom_range(0, 40))
                                        : $urandom;
        idle_gap(no_idle);
        send_frame(f, predict_jitter(f));
      end
    end

    in_valid <= 1'b0;
    while (pending_jitter.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (pending_jitter.size() != 0) begin
      $error("%0d items never came out", pending_jitter.size());
      n_bad = n_bad + 1;
    end
    if (n_bad == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/hsj_pkg.sv
hw/rtl/hsj_phase.sv
hw/rtl/hsj_modidx.sv
hw/rtl/hsj_digits.sv
hw/rtl/halton_subpixel_jitter_top.sv
sim/halton_subpixel_jitter_top_test.sv
